/* rtl/core/sitoa_pkg.sv */
// Shared constants and types for the signed integer to decimal ASCII converter.
// Used by every module in rtl/core; depends on nothing else.
package sitoa_pkg;

  // Input width that is converted; bits above it are ignored.
  localparam int VALUE_WIDTH    = 64;
  // Most decimal digits ever kept for one number.
  localparam int MAX_DIGITS     = 19;
  // BCD digits carried through the pipeline.
  localparam int STORE_DEPTH    = 20;
  // Most characters emitted for one number, sign included.
  localparam int RESULT_LIMIT   = 20;
  // Magnitude bits consumed by each double dabble stage.
  localparam int BITS_PER_STAGE = 4;

  localparam int DABBLE_STAGES = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int MAG_W         = DABBLE_STAGES * BITS_PER_STAGE;
  localparam int BCD_W         = STORE_DEPTH * 4;
  localparam int CNT_W         = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W         = $clog2(STORE_DEPTH);

  localparam int LIMIT_BASE = (MAX_DIGITS < STORE_DEPTH) ? MAX_DIGITS : STORE_DEPTH;
  localparam int LIMIT_POS  = (LIMIT_BASE < RESULT_LIMIT) ? LIMIT_BASE : RESULT_LIMIT;
  localparam int LIMIT_NEG  = (LIMIT_BASE < RESULT_LIMIT - 1) ? LIMIT_BASE
                                                              : RESULT_LIMIT - 1;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_MINUS = 7'h2D;

  // Payload of one double dabble pipeline stage.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] mag;
  } dabble_t;

  // Converted number handed to the character emitter.
  typedef struct packed {
    logic             neg;
    logic [CNT_W-1:0] count;
    logic [BCD_W-1:0] bcd;
  } digits_t;

endpackage

/* rtl/core/signed_int_to_decimal_ascii.sv */
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitoa_pkg, sitoa_dabble, sitoa_count and sitoa_emit.
//
// Each input transaction carries one signed two's complement integer; the block
// answers with its decimal text as a run of output transactions, one ASCII
// character each, most significant digit first, a leading '-' for negative
// values, and tlast on the final character (zero gives the single character
// '0', no NUL is sent). The most negative value converts correctly because the
// magnitude is formed as an unsigned number. Conversion is a pipeline: one
// register stage forms sign and magnitude, DABBLE_STAGES stages of double
// dabble each shift BITS_PER_STAGE magnitude bits into twenty BCD digits (16
// stages for 64 bits), and one stage counts the significant digits. The
// character emitter at the end sends one character per cycle while the output
// side is ready, so a number of n characters (sign included, 1 to 20) holds the
// emitter until its last character is registered for output; the next number
// is loaded in that same cycle. A number that reaches the counting stage while
// the emitter is busy holds the whole pipeline, so s_tready is low only when the
// counting stage holds a number that the emitter cannot yet take.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
  output logic        m_tlast    // last_char
);
  import sitoa_pkg::*;

  logic                   adv;
  logic                   emit_take;
  logic                   v0;
  dabble_t                p0;
  logic                   vld [DABBLE_STAGES+1];
  dabble_t                stg [DABBLE_STAGES+1];
  logic                   cnt_valid;
  digits_t                cnt_data;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   raw_neg;
  logic [VALUE_WIDTH-1:0] raw_mag;
  logic [6:0]             character;

  // The whole pipeline moves together whenever its last stage can be emptied.
  assign adv      = !cnt_valid || emit_take;
  assign s_tready = adv;

  // Sign and magnitude; the negation is taken modulo 2^VALUE_WIDTH, which
  // gives the right unsigned magnitude for the most negative value as well.
  assign raw     = s_tdata[VALUE_WIDTH-1:0];
  assign raw_neg = raw[VALUE_WIDTH-1];
  assign raw_mag = raw_neg ? (~raw + VALUE_WIDTH'(1)) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0.neg <= raw_neg;
      p0.bcd <= '0;
      p0.mag <= MAG_W'(raw_mag);
    end
  end

  assign vld[0] = v0;
  assign stg[0] = p0;

  for (genvar i = 0; i < DABBLE_STAGES; i++) begin : g_dabble
    sitoa_dabble u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (vld[i]),
      .in_data   (stg[i]),
      .out_valid (vld[i+1]),
      .out_data  (stg[i+1])
    );
  end

  sitoa_count u_count (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vld[DABBLE_STAGES]),
    .in_data   (stg[DABBLE_STAGES]),
    .out_valid (cnt_valid),
    .out_data  (cnt_data)
  );

  sitoa_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cnt_valid),
    .in_data   (cnt_data),
    .take      (emit_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .character (character),
    .last_char (m_tlast)
  );

  assign m_tdata = {1'b0, character};

endmodule

/* rtl/core/sitoa_dabble.sv */
// One double dabble stage: shifts BITS_PER_STAGE magnitude bits into the BCD digits.
// Depends on sitoa_pkg.
module sitoa_dabble (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  sitoa_pkg::dabble_t in_data,
  output logic              out_valid,
  output sitoa_pkg::dabble_t out_data
);
  import sitoa_pkg::*;

  dabble_t nxt;

  always_comb begin
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] mag;
    bcd = in_data.bcd;
    mag = in_data.mag;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      for (int d = 0; d < STORE_DEPTH; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], mag[MAG_W-1]};
      mag = {mag[MAG_W-2:0], 1'b0};
    end
    nxt.neg = in_data.neg;
    nxt.bcd = bcd;
    nxt.mag = mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule

/* rtl/core/sitoa_count.sv */
// Counts the significant decimal digits and clamps them to the character budget.
// Depends on sitoa_pkg.
module sitoa_count (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  sitoa_pkg::dabble_t in_data,
  output logic               out_valid,
  output sitoa_pkg::digits_t out_data
);
  import sitoa_pkg::*;

  logic [CNT_W-1:0] sig;
  logic [CNT_W-1:0] limit;
  digits_t          nxt;

  // Zero still has one digit, so the count starts at one.
  always_comb begin
    sig = CNT_W'(1);
    for (int d = 0; d < STORE_DEPTH; d++) begin
      if (in_data.bcd[d*4 +: 4] != 4'd0) begin
        sig = CNT_W'(d + 1);
      end
    end
    limit     = in_data.neg ? CNT_W'(LIMIT_NEG) : CNT_W'(LIMIT_POS);
    nxt.neg   = in_data.neg;
    nxt.count = (sig > limit) ? limit : sig;
    nxt.bcd   = in_data.bcd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule

/* rtl/core/sitoa_emit.sv */
// Character emitter: sends a number's sign and digits, one per unstalled cycle.
// Depends on sitoa_pkg.
module sitoa_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sitoa_pkg::digits_t in_data,
  output logic               take,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [6:0]         character,
  output logic               last_char
);
  import sitoa_pkg::*;

  logic             busy;
  logic             sign_pend;
  logic [CNT_W-1:0] remain;
  logic [3:0]       digits [STORE_DEPTH];
  logic             out_free;
  logic             produce;
  logic             finishing;
  logic [IDX_W-1:0] idx;
  logic [3:0]       digit;

  assign out_free  = !m_tvalid || m_tready;
  assign produce   = busy && out_free;
  assign finishing = produce && !sign_pend && (remain == CNT_W'(1));
  assign take      = !busy || finishing;
  assign idx       = IDX_W'(remain - CNT_W'(1));
  assign digit     = digits[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      remain    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (produce) begin
        m_tvalid <= 1'b1;
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else begin
          remain <= remain - CNT_W'(1);
        end
      end
      if (take && in_valid) begin
        busy      <= 1'b1;
        sign_pend <= in_data.neg;
        remain    <= in_data.count;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      for (int d = 0; d < STORE_DEPTH; d++) begin
        digits[d] <= in_data.bcd[d*4 +: 4];
      end
    end
    if (produce) begin
      character <= sign_pend ? ASCII_MINUS : (ASCII_ZERO + {3'b000, digit});
      last_char <= !sign_pend && (remain == CNT_W'(1));
    end
  end

endmodule

/* sim/sitoa_text_checker.sv */
// Scoreboard for the signed integer to decimal ASCII converter.
// Predicts the character run of every accepted number and checks the output stream.
// Depends on sitoa_pkg for widths, digit limits and ASCII codes.
`timescale 1ns / 1ps

module sitoa_text_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [6:0] character, [7] zero
  input  logic        m_tlast,   // last_char
  output int          mismatch_count,
  output int          chars_pending
);
  import sitoa_pkg::*;

  localparam logic [63:0] RADIX = 64'd10;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  text_char_t text_q[$];
  int         fail_total = 0;

  initial begin
    mismatch_count = 0;
    chars_pending  = 0;
  end

  // Queues the characters that one number turns into: optional sign, then the
  // digits most significant first, with the last flag on the final one.
  function automatic void predict_text(input logic [63:0] word);
    logic [63:0] mask;
    logic [63:0] raw;
    logic [63:0] mag;
    logic        neg;
    logic [3:0]  digits [STORE_DEPTH];
    int          limit;
    int          count;
    int          total;
    int          n;
    mask = (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
    raw  = word & mask;
    neg  = raw[VALUE_WIDTH-1];
    mag  = neg ? ((~raw + 64'd1) & mask) : raw;
    limit = MAX_DIGITS;
    if (limit > STORE_DEPTH) limit = STORE_DEPTH;
    if (limit > RESULT_LIMIT - int'(neg)) limit = RESULT_LIMIT - int'(neg);
    count = 0;
    do begin
      digits[count % STORE_DEPTH] = 4'(mag % RADIX);
      mag = mag / RADIX;
      count++;
    end while (mag != 0 && count < limit);
    total = count + int'(neg);
    n = 0;
    if (neg) begin
      text_q.push_back('{code: ASCII_MINUS, last: 1'b0});
      n++;
    end
    for (int i = count - 1; i >= 0; i--) begin
      n++;
      text_q.push_back('{code: ASCII_ZERO + 7'(digits[i]), last: (n == total)});
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_q.delete();
    end else begin
      if (s_tvalid && s_tready) predict_text(s_tdata);
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected character %h last %b", $realtime, m_tdata, m_tlast);
        end else begin
          want = text_q.pop_front();
          if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: expected character %h last %b, got %h last %b",
                       $realtime, {1'b0, want.code}, want.last, m_tdata, m_tlast);
          end
        end
      end
    end
    mismatch_count <= fail_total;
    chars_pending  <= text_q.size();
  end

endmodule

/* sim/signed_int_to_decimal_ascii_tb.sv */
// Top of the testbench for the signed integer to decimal ASCII converter.
// Drives numbers in and paces the output side; depends on sitoa_text_checker and the RTL.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

  // A number goes through the whole pipeline after it is accepted and then needs
  // up to 20 characters under random back-pressure; this bound is many times
  // the slowest correct run.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 157;
  // Pipeline latency to the first character plus a full 20 character run.
  localparam int TAIL_CYCLES  = 40;

  localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // [63:0] value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [6:0] character, [7] zero
  logic        m_tlast;         // last_char

  // While quiet is set neither side inserts idle cycles.
  logic        quiet       = 1'b0;
  int          cycle_count = 0;
  int          mismatch_count;
  int          chars_pending;

  signed_int_to_decimal_ascii uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sitoa_text_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls with a chance of roughly 37 in 100, except in the quiet stretch.
  always @(posedge clk) begin
    m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 37);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // Offers one number and returns once the transaction has been accepted.
  // Valid is only lowered inside the idle loop, so it never sees two
  // assignments in the same time step.
  task automatic send_value(input logic [63:0] v);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Holds the sender off until every predicted character has come out. The
  // first edge lets the checker's count catch up with the last transaction.
  task automatic drain_output();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] mag;
    logic [63:0] v;
    int          k;
    int          pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: zero, single digits, carries across a power of ten,
    // the longest texts, and both extremes including the most negative value
    // whose magnitude does not fit in a signed word.
    send_value(64'd0);
    send_value(64'd1);
    send_value(-64'sd1);
    send_value(64'd9);
    send_value(-64'sd9);
    send_value(64'd10);
    send_value(-64'sd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(-64'sd100);
    send_value(64'd12345);
    send_value(-64'sd67890);
    send_value(64'd999999999999999999);
    send_value(64'd1000000000000000000);
    send_value(-64'sd1000000000000000000);
    send_value(64'd1234567890123456789);
    send_value(-64'sd1234567890123456789);
    send_value(MOST_POSITIVE);
    send_value(MOST_NEGATIVE);
    send_value(MOST_NEGATIVE + 64'd1);
    send_value(MOST_POSITIVE - 64'd1);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
    drain_output();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 70) quiet <= 1'b1;
      if (n == 120) quiet <= 1'b0;
      if (n == 40 || n == 150) drain_output();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // Any bit pattern at all.
        v = {$urandom, $urandom};
      end else if (pick < 60) begin
        // A random number of digits, so text lengths spread evenly.
        k   = $urandom_range(1, 19);
        mag = {$urandom, $urandom} % pow10(k);
        v   = $urandom_range(0, 1) ? -mag : mag;
      end else if (pick < 75) begin
        // Right around a power of ten, where the digit count changes.
        k   = $urandom_range(1, 18);
        mag = pow10(k) + 64'($urandom_range(0, 2)) - 64'd1;
        v   = $urandom_range(0, 1) ? -mag : mag;
      end else if (pick < 85) begin
        mag = 64'($urandom_range(0, 20));
        v   = $urandom_range(0, 1) ? -mag : mag;
      end else begin
        v = $urandom_range(0, 1) ? MOST_NEGATIVE + 64'($urandom_range(0, 1000))
                                 : MOST_POSITIVE - 64'($urandom_range(0, 1000));
      end
      send_value(v);
    end

    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && chars_pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
